/* rtl/sitda_pkg.sv */
// shared types and constants for the signed integer to decimal ascii unit
`default_nettype none
package sitda_pkg;

    localparam int VALUE_W   = 32;
    localparam int CHAR_W    = 8;
    localparam int NUM_DIGITS = 10;
    localparam int DIGIT_W   = 4;
    localparam int BCD_W     = NUM_DIGITS * DIGIT_W;
    localparam int BIT_CNT_W = 5;
    localparam int DIG_CNT_W = 4;

    localparam logic [CHAR_W-1:0]    DIGIT_BASE = 8'd48;
    localparam logic [CHAR_W-1:0]    MINUS_CODE = 8'd45;
    localparam logic [BIT_CNT_W-1:0] LAST_BIT   = 5'(VALUE_W - 1);
    localparam logic [DIG_CNT_W-1:0] FULL_DIGITS = 4'(NUM_DIGITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    typedef struct packed {
        logic load;        // capture input beat, form magnitude
        logic dabble;      // one shift-add-3 step
        logic skip;        // drop a leading zero digit
        logic emit_sign;   // load minus sign into output register
        logic emit_digit;  // load top digit into output register
        logic emit_last;   // last flag for the emitted digit
    } cmd_t;

    typedef struct packed {
        logic neg;
        logic top_zero;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

/* rtl/sitda_datapath.sv */
// datapath: magnitude and bcd registers, double dabble step, output register
`default_nettype none
module sitda_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [sitda_pkg::VALUE_W-1:0]     value,
    input  wire sitda_pkg::cmd_t                   cmd,
    output sitda_pkg::status_t                     status,
    output logic [sitda_pkg::CHAR_W-1:0]           character,
    output logic                                   last,
    output logic                                   out_valid,
    input  wire logic                              out_ready
);

    localparam int BW = sitda_pkg::BCD_W;
    localparam int DW = sitda_pkg::DIGIT_W;
    localparam int VW = sitda_pkg::VALUE_W;

    logic [VW-1:0]                  mag_reg, mag_next;
    logic [BW-1:0]                  bcd_reg, bcd_next;
    logic                           neg_reg, neg_next;
    logic [sitda_pkg::CHAR_W-1:0]   char_reg, char_next;
    logic                           last_reg, last_next;
    logic                           valid_reg, valid_next;
    logic [BW-1:0]                  adj;
    logic [DW-1:0]                  top_digit;

    assign top_digit = bcd_reg[BW-1 -: DW];

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        adj = bcd_reg;
        for (int i = 0; i < sitda_pkg::NUM_DIGITS; i++)
        begin
            if (bcd_reg[DW*i +: DW] >= 4'd5)
            begin
                adj[DW*i +: DW] = bcd_reg[DW*i +: DW] + 4'd3;
            end
        end
    end

    always_comb
    begin
        mag_next = mag_reg;
        bcd_next = bcd_reg;
        neg_next = neg_reg;
        priority if (cmd.load)
        begin
            neg_next = value[VW-1];
            mag_next = value[VW-1] ? (~value + 32'd1) : value;
            bcd_next = '0;
        end
        else if (cmd.dabble)
        begin
            bcd_next = {adj[BW-2:0], mag_reg[VW-1]};
            mag_next = {mag_reg[VW-2:0], 1'b0};
        end
        else if (cmd.skip || cmd.emit_digit)
        begin
            bcd_next = {bcd_reg[BW-DW-1:0], {DW{1'b0}}};
        end
        else
        begin
            bcd_next = bcd_reg;
        end
    end

    always_comb
    begin
        char_next  = char_reg;
        last_next  = last_reg;
        valid_next = valid_reg && !out_ready;
        priority if (cmd.emit_sign)
        begin
            char_next  = sitda_pkg::MINUS_CODE;
            last_next  = 1'b0;
            valid_next = 1'b1;
        end
        else if (cmd.emit_digit)
        begin
            char_next  = sitda_pkg::DIGIT_BASE + {4'd0, top_digit};
            last_next  = cmd.emit_last;
            valid_next = 1'b1;
        end
        else
        begin
            valid_next = valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign status.neg      = neg_reg;
    assign status.top_zero = (top_digit == '0);
    assign status.out_free = !valid_reg || out_ready;

    assign character = char_reg;
    assign last      = last_reg;
    assign out_valid = valid_reg;

endmodule
`default_nettype wire

/* rtl/sitda_ctrl.sv */
// controller: sequences conversion, leading zero skip and character emission
`default_nettype none
module sitda_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire sitda_pkg::status_t  status,
    output sitda_pkg::cmd_t          cmd
);

    sitda_pkg::state_t                    state_reg, state_next;
    logic [sitda_pkg::BIT_CNT_W-1:0]      bit_cnt_reg, bit_cnt_next;
    logic [sitda_pkg::DIG_CNT_W-1:0]      dig_cnt_reg, dig_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sitda_pkg::ST_IDLE;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        unique case (state_reg)
            sitda_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    bit_cnt_next = sitda_pkg::LAST_BIT;
                    state_next   = sitda_pkg::ST_CONV;
                end
            end
            sitda_pkg::ST_CONV:
            begin
                cmd.dabble   = 1'b1;
                bit_cnt_next = bit_cnt_reg - 5'd1;
                if (bit_cnt_reg == '0)
                begin
                    dig_cnt_next = sitda_pkg::FULL_DIGITS;
                    state_next   = sitda_pkg::ST_SKIP;
                end
            end
            sitda_pkg::ST_SKIP:
            begin
                // keep at least one digit so zero prints as '0'
                if (status.top_zero && dig_cnt_reg > 4'd1)
                begin
                    cmd.skip     = 1'b1;
                    dig_cnt_next = dig_cnt_reg - 4'd1;
                end
                else if (status.neg)
                begin
                    state_next = sitda_pkg::ST_SIGN;
                end
                else
                begin
                    state_next = sitda_pkg::ST_DIGITS;
                end
            end
            sitda_pkg::ST_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = sitda_pkg::ST_DIGITS;
                end
            end
            sitda_pkg::ST_DIGITS:
            begin
                if (status.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    cmd.emit_last  = (dig_cnt_reg == 4'd1);
                    dig_cnt_next   = dig_cnt_reg - 4'd1;
                    if (dig_cnt_reg == 4'd1)
                    begin
                        state_next = sitda_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sitda_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/signed_int_to_decimal_ascii_unit.sv */
// signed 32-bit integer to decimal ascii text, one character per output beat
// the unit runs 32 shift-add-3 conversion steps after the input beat and up to 9 leading
// zero skips, then emits one character per cycle while the output register is free;
// a new input is taken only after every character of the last one has been emitted,
// but the last character may still wait in the output register while the next input is taken
// reset: rst_n asynchronous active low, clears the state machine and output valid
`default_nettype none
module signed_int_to_decimal_ascii_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] character
    output logic             m_tlast
);

    sitda_pkg::cmd_t    cmd;
    sitda_pkg::status_t status;

    sitda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sitda_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .character (m_tdata),
        .last      (m_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

endmodule
`default_nettype wire

/* tb/signed_int_to_decimal_ascii_unit_test.sv */
// self-checking testbench for the signed integer to decimal ascii unit
module signed_int_to_decimal_ascii_unit_test;

    localparam int                VALUE_W    = sitda_pkg::VALUE_W;
    localparam int                CHAR_W     = sitda_pkg::CHAR_W;
    localparam int                NUM_DIGITS = sitda_pkg::NUM_DIGITS;
    localparam logic [CHAR_W-1:0] DIGIT_BASE = sitda_pkg::DIGIT_BASE;
    localparam logic [CHAR_W-1:0] MINUS_CODE = sitda_pkg::MINUS_CODE;

    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              is_last;
    } char_beat_t;

    // predicts the text of each accepted number and checks every output beat
    class text_scoreboard;
        char_beat_t text_queue[$];
        int         errors;
        int         numbers_seen;
        int         negatives;
        int         zeros;
        int         chars_checked;
        int         length_hits[12];

        function void note_value(logic [VALUE_W-1:0] value);
            logic [VALUE_W-1:0] mag;
            logic [3:0]         digs[NUM_DIGITS];
            int                 nd;
            char_beat_t         beat;

            mag = value[VALUE_W-1] ? (~value + 32'd1) : value;
            nd = 0;
            do
            begin
                digs[nd] = 4'(mag % 32'd10);
                mag = mag / 32'd10;
                nd++;
            end
            while (mag != 0 && nd < NUM_DIGITS);

            if (value[VALUE_W-1])
            begin
                beat.code = MINUS_CODE;
                beat.is_last = 1'b0;
                text_queue.push_back(beat);
                negatives++;
            end
            for (int i = nd - 1; i >= 0; i--)
            begin
                beat.code = DIGIT_BASE + 8'(digs[i]);
                beat.is_last = (i == 0);
                text_queue.push_back(beat);
            end
            if (value == '0)
                zeros++;
            length_hits[nd + (value[VALUE_W-1] ? 1 : 0)]++;
            numbers_seen++;
        endfunction

        function void check_char(logic [CHAR_W-1:0] code, logic is_last);
            char_beat_t want;

            chars_checked++;
            if (text_queue.size() == 0)
            begin
                $error("unexpected character beat: character %0d last %0b", code, is_last);
                errors++;
                return;
            end
            want = text_queue.pop_front();
            if (code !== want.code)
            begin
                $error("character: expected %0d, actual %0d", want.code, code);
                errors++;
            end
            if (is_last !== want.is_last)
            begin
                $error("last: expected %0b, actual %0b", want.is_last, is_last);
                errors++;
            end
        endfunction

        function int outstanding();
            return text_queue.size();
        endfunction
    endclass

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_ITEMS = 200;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [VALUE_W-1:0]  s_tdata = '0;     // [31:0] value
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [CHAR_W-1:0]   m_tdata;          // [7:0] character
    logic                m_tlast;

    text_scoreboard      board;
    int                  cycles = 0;
    bit                  send_idle = 1'b1;
    bit                  recv_idle = 1'b1;

    signed_int_to_decimal_ascii_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d characters outstanding",
                     cycles, board.outstanding());
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int draw_gap(bit idle_on);
        return idle_on ? int'($urandom_range(13, 0)) : 0;
    endfunction

    // value with a given digit count and sign
    function automatic logic [VALUE_W-1:0] make_value(int ndig, bit neg);
        longint lo;
        longint hi;
        longint v;

        lo = 1;
        for (int k = 1; k < ndig; k++)
            lo = lo * 10;
        hi = (ndig == NUM_DIGITS) ? 64'd2147483647 : lo * 10 - 1;
        if (ndig == 1)
            lo = 0;
        v = lo + longint'($urandom_range(32'(hi - lo), 0));
        return neg ? VALUE_W'(-v) : VALUE_W'(v);
    endfunction

    // ready is sampled mid-cycle, the beat is taken at the following rising edge
    task automatic send_value(logic [VALUE_W-1:0] value);
        int gap;

        gap = draw_gap(send_idle);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        board.note_value(value);
    endtask

    task automatic wait_for_text();
        while (board.outstanding() != 0)
            @(posedge clk);
    endtask

    // output side: random stalls per beat
    task automatic take_chars();
        int                stall;
        logic [CHAR_W-1:0] code;
        logic              tlast_seen;

        forever
        begin
            stall = draw_gap(recv_idle);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(negedge clk);
            while (!m_tvalid)
                @(negedge clk);
            code       = m_tdata;
            tlast_seen = m_tlast;
            @(posedge clk);
            board.check_char(code, tlast_seen);
        end
    endtask

    initial
    begin
        logic [VALUE_W-1:0] directed[$];
        int                 pick;
        string              lens;

        board = new();
        directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99,
                     32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                     32'd1000000000, 32'd999999999, -32'sd999999999, 32'd1234567890,
                     -32'sd1234567890, 32'd7, -32'sd5, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'd1000000001, -32'sd100};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        fork
            take_chars();
        join_none

        foreach (directed[i])
            send_value(directed[i]);
        s_tvalid <= 1'b0;
        wait_for_text();

        // random part in four chunks, idling on each side set per chunk
        for (int chunk = 0; chunk < 4; chunk++)
        begin
            send_idle = (chunk != 1);
            recv_idle = (chunk != 1) && (chunk != 3);
            for (int n = 0; n < RANDOM_ITEMS / 4; n++)
            begin
                pick = $urandom_range(9, 0);
                if (pick == 0)
                    send_value($urandom());
                else if (pick == 1)
                    send_value($urandom_range(1, 0) ? 32'h8000_0000 : 32'd0);
                else
                    send_value(make_value($urandom_range(NUM_DIGITS, 1),
                                          $urandom_range(1, 0)));
            end
            s_tvalid <= 1'b0;
            // hold off until every character of this chunk is out
            wait_for_text();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        lens = "";
        for (int n = 1; n < 12; n++)
            lens = {lens, $sformatf(" %0d", board.length_hits[n])};
        $display("converted %0d numbers (%0d negative, %0d zero), %0d characters checked",
                 board.numbers_seen, board.negatives, board.zeros, board.chars_checked);
        $display("text lengths 1..11 seen:%s", lens);
        if (board.errors == 0 && board.outstanding() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
